FILE: sv/xxtd_pkg.sv
// Package for the XXTEA block decrypt unit: sizes, scheme constants,
// controller state and command types, and the MX mixing function.
// No dependencies.
package xxtd_pkg;

	localparam int ROUND_COUNT = 12;
	localparam int BLOCK_WORDS = 8;
	localparam int KEY_WORDS   = 4;
	localparam int WORD_W      = 32;
	localparam int IDX_W       = $clog2(BLOCK_WORDS);
	localparam int KEY_IDX_W   = $clog2(KEY_WORDS);
	localparam int RND_W       = $clog2(ROUND_COUNT);
	localparam int CFG_IDX_W   = 8;
	localparam int BLOCK_W     = BLOCK_WORDS * WORD_W;

	localparam logic [WORD_W-1:0] DELTA     = 32'h9E3779B9;
	// Adding the two's complement of the delta steps the sum down by one round.
	localparam logic [WORD_W-1:0] DELTA_NEG = 32'h61C88647;
	localparam logic [63:0]       SUM_PROD  = 64'(ROUND_COUNT) * 64'(DELTA);
	localparam logic [WORD_W-1:0] SUM_INIT  = SUM_PROD[WORD_W-1:0];

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic             load;
		logic             step;
		logic [IDX_W-1:0] word_idx;
		logic             round_end;
		logic             capture;
	} dp_cmd_t;

	function automatic logic [WORD_W-1:0] mx(
		input logic [WORD_W-1:0] y,
		input logic [WORD_W-1:0] z,
		input logic [WORD_W-1:0] sum,
		input logic [WORD_W-1:0] k
	);
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
		left  = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
		right = (sum ^ y) + (k ^ z);
		return left ^ right;
	endfunction

endpackage

FILE: sv/xxtd_datapath.sv
// Datapath of the XXTEA decrypt unit: key registers, rotating word line,
// running sum, shared mixing unit and output register.
// Depends on xxtd_pkg.
module xxtd_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  xxtd_pkg::dp_cmd_t                  cmd,
	input  logic                               cfg_we,
	input  logic [xxtd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [xxtd_pkg::WORD_W-1:0]        cfg_data,
	input  logic [xxtd_pkg::BLOCK_W-1:0]       s_tdata,
	output logic [xxtd_pkg::BLOCK_W-1:0]       m_tdata
);
	import xxtd_pkg::*;

	logic [WORD_W-1:0]    key_q [KEY_WORDS];
	logic [WORD_W-1:0]    w_q   [BLOCK_WORDS];
	logic [WORD_W-1:0]    out_q [BLOCK_WORDS];
	logic [WORD_W-1:0]    sum_q;
	logic [KEY_IDX_W-1:0] key_sel;
	logic [WORD_W-1:0]    new_word;

	// The line is kept rotated so that the word under update sits in the top
	// slot, its successor in slot 0 and its predecessor just below the top.
	assign key_sel  = cmd.word_idx[KEY_IDX_W-1:0] ^ sum_q[3:2];
	assign new_word = w_q[BLOCK_WORDS-1]
		- mx(w_q[0], w_q[BLOCK_WORDS-2], sum_q, key_q[key_sel]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) key_q[i] <= '0;
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(KEY_WORDS))) begin
			key_q[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < BLOCK_WORDS; i++) w_q[i] <= s_tdata[i*WORD_W +: WORD_W];
			sum_q <= SUM_INIT;
		end else begin
			if (cmd.step) begin
				w_q[0] <= new_word;
				for (int i = 1; i < BLOCK_WORDS; i++) w_q[i] <= w_q[i-1];
			end
			if (cmd.round_end) begin
				sum_q <= sum_q + DELTA_NEG;
			end
		end
		if (cmd.capture) begin
			for (int i = 0; i < BLOCK_WORDS; i++) out_q[i] <= w_q[i];
		end
	end

	always_comb begin
		for (int i = 0; i < BLOCK_WORDS; i++) m_tdata[i*WORD_W +: WORD_W] = out_q[i];
	end

endmodule

FILE: sv/xxtd_ctrl.sv
// Controller of the XXTEA decrypt unit: block sequencing, word and round
// counters, output valid flag. Depends on xxtd_pkg.
module xxtd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output xxtd_pkg::dp_cmd_t cmd
);
	import xxtd_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] p_q;
	logic [RND_W-1:0] rnd_q;
	logic             out_valid_q;
	logic             last_step;
	logic             out_free;

	assign last_step = (p_q == '0) && (rnd_q == RND_W'(ROUND_COUNT - 1));
	assign out_free  = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_RUN;
			ST_RUN:   if (last_step) state_d = ST_DRAIN;
			ST_DRAIN: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.step      = 1'b0;
		cmd.word_idx  = p_q;
		cmd.round_end = 1'b0;
		cmd.capture   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_RUN: begin
				cmd.step      = 1'b1;
				cmd.round_end = (p_q == '0);
			end
			ST_DRAIN: begin
				cmd.capture = out_free;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			p_q         <= '0;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				p_q   <= IDX_W'(BLOCK_WORDS - 1);
				rnd_q <= '0;
			end else if (cmd.step) begin
				p_q <= (p_q == '0) ? IDX_W'(BLOCK_WORDS - 1) : p_q - 1'b1;
				if (cmd.round_end && !last_step) rnd_q <= rnd_q + 1'b1;
			end
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_RUN) && (p_q == IDX_W'(BLOCK_WORDS - 1)) && (rnd_q == '0))
		else $error("load did not start a fresh run");
	a_last_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && last_step |=> (state_q == ST_DRAIN))
		else $error("run did not end after the last word update");
	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (!out_valid_q || m_tready))
		else $error("capture would overwrite an untaken result");
	a_capture_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> m_tvalid && (state_q == ST_IDLE))
		else $error("captured result not presented");
`endif

endmodule

FILE: sv/xxtea_block_decrypt_unit.sv
// Top level of the XXTEA 8-word block decrypt unit: key write port, input
// and output streams. Depends on xxtd_pkg, xxtd_ctrl and xxtd_datapath.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  cfg      | cfg_valid/ready   | cfg_index (key word 0..3), cfg_data
//  s_ (in)  | s_tvalid/tready   | s_tdata: cipher_0 .. cipher_7
//  m_ (out) | m_tvalid/tready   | m_tdata: plain_0 .. plain_7
//
// One block goes through one load, 96 word updates (12 rounds of 8) through
// the single shared mixing unit, and one capture.
// Reset clears the key to zero and empties the unit.
// A finished result waits in the output register; the next block is taken
// meanwhile and only its capture waits until that register is free.
// Writes to cfg_index beyond the key are ignored.
module xxtea_block_decrypt_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [xxtd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [xxtd_pkg::WORD_W-1:0]    cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [xxtd_pkg::BLOCK_W-1:0]   s_tdata,  // cipher_0 [31:0] .. cipher_7 [255:224]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [xxtd_pkg::BLOCK_W-1:0]   m_tdata   // plain_0 [31:0] .. plain_7 [255:224]
);
	import xxtd_pkg::*;

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	xxtd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	xxtd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata)
	);

endmodule
